FILE: rtl/core/pressure_temperature_compensation_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pressure and temperature compensation block.
// Each macro expands to one labeled concurrent assertion on the given clock.
// ----------------------------------------------------------------------------
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_TOP_ASSERT_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_TOP_ASSERT_SVH

// Checked outside reset only.
`define PTC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising clock edge, reset included.
`define PTC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/core/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg
// Types and constants shared by the compensation front, queue and back end.
// ----------------------------------------------------------------------------
package ptc_pkg;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_TEMP_TRIM      = 2'd0,
        REG_PRES_TRIM_LOW  = 2'd1,
        REG_PRES_TRIM_MID  = 2'd2,
        REG_PRES_TRIM_HIGH = 2'd3
    } t_reg_idx;

    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned DIV_W      = 64;

    // Fixed scaling constants of the compensation formulas.
    localparam logic signed [26:0] FINE_OFFSET     = 27'sd128000;
    localparam logic [20:0]        PRES_FULL_SCALE = 21'd1048576;
    localparam logic [63:0]        PRES_SCALE      = 64'd3125;
    localparam logic signed [28:0] CENTI_ROUND     = 29'sd128;
    localparam int unsigned        P4_SHIFT        = 35;
    localparam logic [63:0]        P1_BIAS         = 64'd1 << 47;

    // Unpacked trimming coefficients, raw 16-bit slices.
    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
    } t_trim;

    // Word handed from the front end to the divider back end.
    typedef struct packed {
        logic [23:0] cent;
        logic [25:0] fine;
        logic        fault;
        logic        neg;
        logic [63:0] num_mag;
        logic [63:0] den_mag;
    } t_div_word;

endpackage

FILE: rtl/core/ptc_sample_if.sv
// ----------------------------------------------------------------------------
// ptc_sample_if
// Input channel: one raw pressure and one raw temperature conversion per word.
// ----------------------------------------------------------------------------
interface ptc_sample_if;
    logic        valid;
    logic        ready;
    logic [19:0] adc_pressure;
    logic [19:0] adc_temperature;

    modport source (output valid, output adc_pressure, output adc_temperature, input ready);
    modport sink   (input valid, input adc_pressure, input adc_temperature, output ready);
endinterface

FILE: rtl/core/ptc_result_if.sv
// ----------------------------------------------------------------------------
// ptc_result_if
// Output channel: compensated temperature and pressure per word.
// ----------------------------------------------------------------------------
interface ptc_result_if;
    logic        valid;
    logic        ready;
    logic [23:0] temperature_centi;
    logic [25:0] fine_temperature;
    logic [31:0] pressure_q24_8;
    logic        divide_fault;

    modport source (output valid, output temperature_centi, output fine_temperature,
                    output pressure_q24_8, output divide_fault, input ready);
    modport sink   (input valid, input temperature_centi, input fine_temperature,
                    input pressure_q24_8, input divide_fault, output ready);
endinterface

FILE: rtl/core/ptc_front.sv
// ----------------------------------------------------------------------------
// ptc_front
// Nine-stage pipeline: temperature compensation, then the pressure numerator
// and divisor, handed to the queue as signed magnitudes.
// ----------------------------------------------------------------------------
module ptc_front
    import ptc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_trim             i_trim,
    ptc_sample_if.sink        i_sample,
    input  logic              i_full,
    output logic              o_push,
    output t_div_word         o_word
);

    logic        f_en;
    logic [9:1]  r_fv;

    // Stage registers.
    logic signed [33:0] r1_ta, r1_dd;
    logic signed [37:0] r2_tb;
    logic signed [22:0] r2_ta11;
    logic signed [25:0] r3_fine;
    logic signed [26:0] r4_pa;
    logic signed [53:0] r5_aa;
    logic signed [42:0] r5_ap5, r5_ap2;
    logic signed [42:0] r6_ap5, r6_ap2;
    logic [63:0] r6_b1, r6_a1;
    logic [63:0] r7_b, r7_a;
    logic [63:0] r8_v, r8_n0;
    logic [63:0] r9_den, r9_num;
    logic [19:0] r_adcp [1:7];
    logic [23:0] r_cent [4:9];
    logic [25:0] r_fine [4:9];

    // Combinational values per stage.
    logic signed [17:0] n_x1;
    logic signed [16:0] n_dt;
    logic signed [33:0] n_ta, n_dd;
    logic signed [21:0] n_dd12;
    logic signed [37:0] n_tb;
    logic signed [25:0] n_fine;
    logic signed [28:0] n_fx, n_f5;
    logic signed [26:0] n_pa;
    logic signed [53:0] n_aa;
    logic signed [42:0] n_ap5, n_ap2;
    logic signed [63:0] n_b1, n_a1;
    logic [63:0] n_b, n_a;
    logic [20:0] n_pd;
    logic [63:0] n_v, n_n0, n_den, n_num;

    // The pipeline moves unless its last word is blocked by a full queue.
    // No word is taken while reset is held.
    assign f_en           = !(r_fv[9] && i_full);
    assign i_sample.ready = f_en && i_rst_n;
    assign o_push         = r_fv[9] && !i_full;

    // Temperature terms.
    always_comb begin
        n_x1   = $signed({1'b0, i_sample.adc_temperature[19:3]})
               - $signed({1'b0, i_trim.t1, 1'b0});
        n_dt   = $signed({1'b0, i_sample.adc_temperature[19:4]}) - $signed({1'b0, i_trim.t1});
        n_ta   = n_x1 * $signed(i_trim.t2);
        n_dd   = n_dt * n_dt;
        n_dd12 = r1_dd[33:12];
        n_tb   = n_dd12 * $signed(i_trim.t3);
        n_fine = $signed(r2_ta11) + $signed(r2_tb[37:14]);
        n_fx   = r3_fine;
        n_f5   = (n_fx <<< 2) + n_fx + CENTI_ROUND;
        n_pa   = 27'(n_fx) - FINE_OFFSET;
    end

    // Pressure numerator and divisor terms, all modulo 2^64.
    always_comb begin
        n_aa  = r4_pa * r4_pa;
        n_ap5 = r4_pa * $signed(i_trim.p5);
        n_ap2 = r4_pa * $signed(i_trim.p2);
        n_b1  = $signed(r5_aa) * $signed(i_trim.p6);
        n_a1  = $signed(r5_aa) * $signed(i_trim.p3);
        n_b   = r6_b1 + ({{21{r6_ap5[42]}}, r6_ap5} << 17)
              + ({{48{i_trim.p4[15]}}, i_trim.p4} << P4_SHIFT);
        n_a   = {{8{r6_a1[63]}}, r6_a1[63:8]} + ({{21{r6_ap2[42]}}, r6_ap2} << 12);
        n_v   = (P1_BIAS + r7_a) * {48'b0, i_trim.p1};
        n_pd  = PRES_FULL_SCALE - {1'b0, r_adcp[7]};
        n_n0  = {12'b0, n_pd, 31'b0} - r7_b;
        n_den = {{33{r8_v[63]}}, r8_v[63:33]};
        n_num = r8_n0 * PRES_SCALE;
    end

    // Word for the divider: magnitudes, the quotient sign, the zero-divisor fault and the temperatures.
    always_comb begin
        o_word.cent    = r_cent[9];
        o_word.fine    = r_fine[9];
        o_word.fault   = (r9_den == '0);
        o_word.neg     = r9_num[63] ^ r9_den[63];
        o_word.num_mag = r9_num[63] ? (64'd0 - r9_num) : r9_num;
        o_word.den_mag = r9_den[63] ? (64'd0 - r9_den) : r9_den;
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
        end else if (f_en) begin
            r_fv <= {r_fv[8:1], i_sample.valid};
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (f_en) begin
            r1_ta     <= n_ta;
            r1_dd     <= n_dd;
            r_adcp[1] <= i_sample.adc_pressure;
            for (int k = 2; k <= 7; k++) begin
                r_adcp[k] <= r_adcp[k-1];
            end
            r2_ta11   <= r1_ta[33:11];
            r2_tb     <= n_tb;
            r3_fine   <= n_fine;
            r4_pa     <= n_pa;
            r_cent[4] <= {{3{n_f5[28]}}, n_f5[28:8]};
            r_fine[4] <= r3_fine;
            for (int k = 5; k <= 9; k++) begin
                r_cent[k] <= r_cent[k-1];
                r_fine[k] <= r_fine[k-1];
            end
            r5_aa     <= n_aa;
            r5_ap5    <= n_ap5;
            r5_ap2    <= n_ap2;
            r6_b1     <= n_b1;
            r6_a1     <= n_a1;
            r6_ap5    <= r5_ap5;
            r6_ap2    <= r5_ap2;
            r7_b      <= n_b;
            r7_a      <= n_a;
            r8_v      <= n_v;
            r8_n0     <= n_n0;
            r9_den    <= n_den;
            r9_num    <= n_num;
        end
    end

endmodule

FILE: rtl/core/ptc_queue.sv
// ----------------------------------------------------------------------------
// ptc_queue
// Short register FIFO that decouples the front end from the divider.
// ----------------------------------------------------------------------------
`include "pressure_temperature_compensation_top_assert.svh"

module ptc_queue
    import ptc_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_div_word i_word,
    output logic      o_full,
    input  logic      i_pop,
    output logic      o_empty,
    output t_div_word o_word
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    t_div_word        r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_word  = r_mem[r_rd];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_word;
        end
    end

    `PTC_ASSERT(a_no_overflow, i_clk, i_rst_n, !(i_push && o_full), "push into a full queue")
    `PTC_ASSERT(a_no_underflow, i_clk, i_rst_n, !(i_pop && o_empty), "pop from an empty queue")
    `PTC_ASSERT(a_count_up, i_clk, i_rst_n, (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1), "fill count lost a push")
    `PTC_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH), "fill count above depth")

endmodule

FILE: rtl/core/ptc_back.sv
// ----------------------------------------------------------------------------
// ptc_back
// 64-stage restoring divider followed by the pressure correction stages and
// the output register.
// ----------------------------------------------------------------------------
module ptc_back
    import ptc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_trim        i_trim,
    input  logic         i_avail,
    input  t_div_word    i_word,
    output logic         o_pop,
    ptc_result_if.source o_result
);

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] num;
        logic [63:0] den;
        logic        neg;
        logic        fault;
        logic [23:0] cent;
        logic [25:0] fine;
    } t_div_stage;

    typedef struct packed {
        logic        fault;
        logic [23:0] cent;
        logic [25:0] fine;
    } t_side;

    logic       b_en;
    logic       r_out_vld;
    logic [DIV_W:0] r_dv;
    t_div_stage r_div [DIV_W+1];
    logic [5:1] r_pv;
    t_side      r_side [1:5];

    logic [63:0] r_p1_p, r_p2_p, r_p3_p, r_p4_p, r_p5_sum;
    logic [63:0] r_p2_pll, r_p2_pb;
    logic [31:0] r_p2_sh, r_p2_sl;
    logic [63:0] r_p3_ss, r_p3_pbs, r_p4_q, r_p4_pbs;
    logic [23:0] r_out_cent;
    logic [25:0] r_out_fine;
    logic [31:0] r_out_pres;
    logic        r_out_fault;

    logic [63:0] n_s, n_pll, n_ss, n_sum, n_v;
    logic signed [63:0] n_pb, n_q;
    logic [31:0] n_cross;
    logic [31:0] n_pres;

    // Whole back end advances while the output register can move.
    assign b_en  = !r_out_vld || o_result.ready;
    assign o_pop = b_en && i_avail;

    // Divider: one quotient bit per stage.
    for (genvar k = 0; k < DIV_W; k++) begin : g_div
        logic [64:0] n_sh, n_diff;
        t_div_stage  n_stage;
        always_comb begin
            n_stage     = r_div[k];
            n_sh        = {r_div[k].rem, r_div[k].num[63]};
            n_diff      = n_sh - {1'b0, r_div[k].den};
            n_stage.rem = n_diff[64] ? n_sh[63:0] : n_diff[63:0];
            n_stage.num = {r_div[k].num[62:0], !n_diff[64]};
        end
        always_ff @(posedge i_clk) begin
            if (b_en) begin
                r_div[k+1] <= n_stage;
            end
        end
    end

    // Correction terms, all modulo 2^64.
    always_comb begin
        n_s     = {{13{r_p1_p[63]}}, r_p1_p[63:13]};
        n_pll   = {32'b0, n_s[31:0]} * {32'b0, n_s[31:0]};
        n_pb    = $signed(r_p1_p) * $signed(i_trim.p8);
        n_cross = r_p2_sh * r_p2_sl;
        n_ss    = r_p2_pll + {n_cross[30:0], 33'b0};
        n_q     = $signed(r_p3_ss) * $signed(i_trim.p9);
        n_sum   = r_p4_p + {{25{r_p4_q[63]}}, r_p4_q[63:25]} + r_p4_pbs;
        n_v     = {{8{r_p5_sum[63]}}, r_p5_sum[63:8]}
                + {{44{i_trim.p7[15]}}, i_trim.p7, 4'b0};
    end

    // Saturate to 32 bits unsigned; a zero divisor or a negative result forces zero.
    always_comb begin
        if (r_side[5].fault || n_v[63]) begin
            n_pres = '0;
        end else if (|n_v[62:32]) begin
            n_pres = '1;
        end else begin
            n_pres = n_v[31:0];
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv      <= '0;
            r_pv      <= '0;
            r_out_vld <= 1'b0;
        end else if (b_en) begin
            r_dv      <= {r_dv[DIV_W-1:0], i_avail};
            r_pv      <= {r_pv[4:1], r_dv[DIV_W]};
            r_out_vld <= r_pv[5];
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_div[0].rem   <= '0;
            r_div[0].num   <= i_word.num_mag;
            r_div[0].den   <= i_word.den_mag;
            r_div[0].neg   <= i_word.neg;
            r_div[0].fault <= i_word.fault;
            r_div[0].cent  <= i_word.cent;
            r_div[0].fine  <= i_word.fine;

            r_p1_p    <= r_div[DIV_W].neg ? (64'd0 - r_div[DIV_W].num) : r_div[DIV_W].num;
            r_side[1] <= '{fault: r_div[DIV_W].fault, cent: r_div[DIV_W].cent,
                           fine: r_div[DIV_W].fine};
            for (int k = 2; k <= 5; k++) begin
                r_side[k] <= r_side[k-1];
            end

            r_p2_p   <= r_p1_p;
            r_p2_pll <= n_pll;
            r_p2_sh  <= n_s[63:32];
            r_p2_sl  <= n_s[31:0];
            r_p2_pb  <= n_pb;

            r_p3_p   <= r_p2_p;
            r_p3_ss  <= n_ss;
            r_p3_pbs <= {{19{r_p2_pb[63]}}, r_p2_pb[63:19]};

            r_p4_p   <= r_p3_p;
            r_p4_q   <= n_q;
            r_p4_pbs <= r_p3_pbs;

            r_p5_sum <= n_sum;

            r_out_cent  <= r_side[5].cent;
            r_out_fine  <= r_side[5].fine;
            r_out_fault <= r_side[5].fault;
            r_out_pres  <= n_pres;
        end
    end

    assign o_result.valid             = r_out_vld;
    assign o_result.temperature_centi = r_out_cent;
    assign o_result.fine_temperature  = r_out_fine;
    assign o_result.pressure_q24_8    = r_out_pres;
    assign o_result.divide_fault      = r_out_fault;

endmodule

FILE: rtl/core/pressure_temperature_compensation_top.sv
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_top
// Integer compensation of raw barometric pressure and temperature readings.
// ----------------------------------------------------------------------------
// Usage:
// - i_sample takes one word per valid/ready handshake: raw 20-bit pressure and
//   temperature. o_result gives one word per sample, in order: temperature in
//   hundredths of a degree, fine temperature, pressure in Pa as Q24.8 and a
//   divide fault flag.
// - Trim coefficients are written through i_cfg_we / i_cfg_idx / i_cfg_wdata
//   while no sample is in flight; a write lands at the next clock edge.
// - Throughput is one sample per cycle while o_result.ready stays high. A
//   sample passes nine front stages, the queue, the divider's load register,
//   64 divider stages (one quotient bit each) and six correction and output
//   stages.
// - When the receiver holds ready low, the back end holds once its output
//   word is valid, and the queue keeps taking words from the front end until
//   it fills; only then does i_sample.ready fall.
// - Reset (i_rst_n low, synchronous) empties the pipelines and the queue and
//   clears all trim registers to zero.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation_top
    import ptc_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ptc_sample_if.sink            i_sample,
    ptc_result_if.source          o_result,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic [47:0] r_temp_trim;
    logic [63:0] r_pres_low;
    logic [63:0] r_pres_mid;
    logic [15:0] r_pres_high;
    t_trim       trim;

    logic      push, full, pop, empty;
    t_div_word front_word, queue_word;

    // Trim register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_trim <= '0;
            r_pres_low  <= '0;
            r_pres_mid  <= '0;
            r_pres_high <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_TEMP_TRIM:      r_temp_trim <= i_cfg_wdata[47:0];
                REG_PRES_TRIM_LOW:  r_pres_low  <= i_cfg_wdata;
                REG_PRES_TRIM_MID:  r_pres_mid  <= i_cfg_wdata;
                REG_PRES_TRIM_HIGH: r_pres_high <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // Coefficient slices.
    always_comb begin
        trim.t1 = r_temp_trim[15:0];
        trim.t2 = r_temp_trim[31:16];
        trim.t3 = r_temp_trim[47:32];
        trim.p1 = r_pres_low[15:0];
        trim.p2 = r_pres_low[31:16];
        trim.p3 = r_pres_low[47:32];
        trim.p4 = r_pres_low[63:48];
        trim.p5 = r_pres_mid[15:0];
        trim.p6 = r_pres_mid[31:16];
        trim.p7 = r_pres_mid[47:32];
        trim.p8 = r_pres_mid[63:48];
        trim.p9 = r_pres_high;
    end

    ptc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_trim   (trim),
        .i_sample (i_sample),
        .i_full   (full),
        .o_push   (push),
        .o_word   (front_word)
    );

    ptc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (front_word),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_word  (queue_word)
    );

    ptc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_trim   (trim),
        .i_avail  (!empty),
        .i_word   (queue_word),
        .o_pop    (pop),
        .o_result (o_result)
    );

endmodule
